// ===== rtl/core/mqtt_fixed_header_parser_assert.svh =====
// Assertion macros for the fixed header parser
`ifndef MQTT_FIXED_HEADER_PARSER_ASSERT_SVH
`define MQTT_FIXED_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define MFHP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFHP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mfhp_pkg.sv =====
package mfhp_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FORBIDDEN = 2'd1;
  localparam logic [1:0] STATUS_BAD_FLAGS = 2'd2;
  localparam logic [1:0] STATUS_TOO_LONG  = 2'd3;

  localparam logic [3:0] TYPE_RESERVED_LO = 4'd0;
  localparam logic [3:0] TYPE_RESERVED_HI = 4'd15;
  localparam logic [3:0] TYPE_PUBLISH     = 4'd3;
  localparam logic [3:0] TYPE_PUBREL      = 4'd6;
  localparam logic [3:0] TYPE_SUBSCRIBE   = 4'd8;
  localparam logic [3:0] TYPE_UNSUBSCRIBE = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  packet_type;
    logic [3:0]  packet_flags;
    logic [27:0] body_length;
    logic [2:0]  header_size;
    logic [1:0]  status;
  } out_item_t;

  // finished header as it travels from front to back
  typedef struct packed {
    logic [3:0]  packet_type;
    logic [3:0]  packet_flags;
    logic [27:0] body_length;
    logic [2:0]  header_size;
    logic        too_long;
  } hdr_rec_t;

  function automatic logic [3:0] need_flags(input logic [3:0] ptype);
    logic [3:0] r;
    unique case (ptype)
      TYPE_PUBREL, TYPE_SUBSCRIBE, TYPE_UNSUBSCRIBE: r = 4'b0010;
      default:                                       r = 4'b0000;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] need_mask(input logic [3:0] ptype);
    logic [3:0] r;
    unique case (ptype)
      TYPE_RESERVED_LO, TYPE_PUBLISH, TYPE_RESERVED_HI: r = 4'b0000;
      default:                                          r = 4'b1111;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/mfhp_front.sv =====
module mfhp_front #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  mfhp_pkg::in_item_t item,
  output logic              rec_valid,
  output mfhp_pkg::hdr_rec_t rec
);

  logic        in_length_r, in_length_nxt;
  logic [3:0]  held_type_r, held_type_nxt;
  logic [3:0]  held_flags_r, held_flags_nxt;
  logic [27:0] length_sum_r, length_sum_nxt;
  logic [2:0]  byte_count_r, byte_count_nxt;

  logic [5:0]  shamt;
  logic [27:0] add;
  logic [27:0] sum;
  logic [3:0]  count;
  logic [3:0]  size_full;

  assign shamt     = {byte_count_r, 3'b000} - {3'b000, byte_count_r};
  assign add       = {21'd0, item.data_byte[6:0]} << shamt;
  assign sum       = length_sum_r + add;
  assign count     = {1'b0, byte_count_r} + 4'd1;
  assign size_full = count + 4'd1;

  always_comb begin
    in_length_nxt  = in_length_r;
    held_type_nxt  = held_type_r;
    held_flags_nxt = held_flags_r;
    length_sum_nxt = length_sum_r;
    byte_count_nxt = byte_count_r;
    rec_valid      = 1'b0;
    if (take) begin
      if (item.restart || !in_length_r) begin
        held_type_nxt  = item.data_byte[7:4];
        held_flags_nxt = item.data_byte[3:0];
        length_sum_nxt = '0;
        byte_count_nxt = '0;
        in_length_nxt  = 1'b1;
      end else begin
        length_sum_nxt = sum;
        if (item.data_byte[7] && (count < 4'(MAX_LENGTH_BYTES))) begin
          byte_count_nxt = count[2:0];
        end else begin
          rec_valid      = 1'b1;
          in_length_nxt  = 1'b0;
          byte_count_nxt = '0;
        end
      end
    end
  end

  always_comb begin
    rec.packet_type  = held_type_r;
    rec.packet_flags = held_flags_r;
    rec.body_length  = sum;
    rec.header_size  = (size_full > 4'd7) ? 3'd7 : size_full[2:0];
    rec.too_long     = item.data_byte[7];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_length_r  <= 1'b0;
      held_type_r  <= '0;
      held_flags_r <= '0;
      length_sum_r <= '0;
      byte_count_r <= '0;
    end else begin
      in_length_r  <= in_length_nxt;
      held_type_r  <= held_type_nxt;
      held_flags_r <= held_flags_nxt;
      length_sum_r <= length_sum_nxt;
      byte_count_r <= byte_count_nxt;
    end
  end

endmodule

// ===== rtl/core/mfhp_queue.sv =====
module mfhp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  mfhp_pkg::hdr_rec_t wr_data,
  input  logic               rd_en,
  output mfhp_pkg::hdr_rec_t rd_data,
  output logic               q_full,
  output logic               q_empty
);

  localparam int PW = $clog2(mfhp_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(mfhp_pkg::QUEUE_DEPTH + 1);

  mfhp_pkg::hdr_rec_t mem_r [mfhp_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  assign q_full  = (count_r == CW'(mfhp_pkg::QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(mfhp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(mfhp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/mfhp_back.sv =====
module mfhp_back (
  input  mfhp_pkg::hdr_rec_t rec,
  output mfhp_pkg::out_item_t item
);

  logic [1:0] rule_status;

  // forbidden type wins over flag mismatch
  always_comb begin
    if (rec.packet_type == mfhp_pkg::TYPE_RESERVED_LO ||
        rec.packet_type == mfhp_pkg::TYPE_RESERVED_HI) begin
      rule_status = mfhp_pkg::STATUS_FORBIDDEN;
    end else if (((rec.packet_flags ^ mfhp_pkg::need_flags(rec.packet_type)) &
                  mfhp_pkg::need_mask(rec.packet_type)) != 4'b0000) begin
      rule_status = mfhp_pkg::STATUS_BAD_FLAGS;
    end else begin
      rule_status = mfhp_pkg::STATUS_OK;
    end
  end

  always_comb begin
    item.packet_type  = rec.packet_type;
    item.packet_flags = rec.packet_flags;
    item.body_length  = rec.body_length;
    item.header_size  = rec.header_size;
    item.status       = rec.too_long ? mfhp_pkg::STATUS_TOO_LONG : rule_status;
  end

endmodule

// ===== rtl/core/mqtt_fixed_header_parser.sv =====
// channel  | handshake         | payload
// ---------+-------------------+--------------------------------------------
// input    | push / full       | in_item  (data_byte, restart)
// result   | pop / empty       | out_item (type, flags, length, size, status)
//
// One header byte is taken per cycle while full is low; the length
// accumulator updates in the same cycle, so bytes stream with no bubbles.
// A finished header enters a two-entry queue; out_item shows the oldest unread one.
// full rises only when the queue holds two unread results.
// Synchronous active-low reset clears parser state and empties the queue.
`include "mqtt_fixed_header_parser_assert.svh"

module mqtt_fixed_header_parser #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  mfhp_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output mfhp_pkg::out_item_t out_item
);

  logic               take;
  logic               rec_valid;
  mfhp_pkg::hdr_rec_t rec;
  mfhp_pkg::hdr_rec_t head;
  logic               q_full;

  assign take = push && !q_full;
  assign full = q_full;

  mfhp_front #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .item     (in_item),
    .rec_valid(rec_valid),
    .rec      (rec)
  );

  mfhp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (rec_valid),
    .wr_data(rec),
    .rd_en  (pop),
    .rd_data(head),
    .q_full (q_full),
    .q_empty(empty)
  );

  mfhp_back u_back (
    .rec (head),
    .item(out_item)
  );

  `MFHP_ASSERT_IMPL(a_no_drop, clk, rst_n, rec_valid, !q_full, "header finished into a full queue")
  `MFHP_ASSERT_IMPL(a_restart_quiet, clk, rst_n, take && in_item.restart, !rec_valid, "restart byte produced a result")
  `MFHP_ASSERT_IMPL(a_size_min, clk, rst_n, !empty, out_item.header_size >= 3'd2, "header size below two")
  `MFHP_ASSERT_NEXT(a_result_lands, clk, rst_n, rec_valid, !empty, "finished header not visible")

endmodule
